/* rtl/fra_pkg.sv */
`default_nettype none

package fra_pkg;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_PASSED    = 3'd1,
    ST_DISCARDED = 3'd2,
    ST_COMPLETE  = 3'd3,
    ST_BUSY      = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_READ      = 3'd6,
    ST_EMPTY     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    MODE_DISCARD = 2'd0,
    MODE_PASS    = 2'd1,
    MODE_APPEND  = 2'd2,
    MODE_FINISH  = 2'd3
  } mode_t;

  localparam logic [1:0] FLAG_MIDDLE = 2'd0;
  localparam logic [1:0] FLAG_FIRST  = 2'd1;
  localparam logic [1:0] FLAG_LAST   = 2'd2;
  localparam logic [1:0] FLAG_SINGLE = 2'd3;

  localparam int LEN_W = 13;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       pend;
    status_t    status;
    logic       dropped;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

/* rtl/fragment_reassembler.sv */
`default_nettype none

// Reassembles fragmented packets arriving one content byte per beat and reads
// the finished packet back one byte per read beat. Every beat yields exactly one
// result beat, in order. The block takes one beat per cycle while the queue is
// not full: a front stage decides each beat's fate and updates the reassembly
// state in the cycle it is accepted, and a back stage performs the packet
// buffer write or read through the single buffer port and holds the result in
// an output register. A four-entry queue between the two lets input and output
// stall independently. The user must write max_length through the cfg port
// only while the block is idle; the block does not enforce this. The effective
// limit is the smaller of max_length and BUF_BYTES.
module fragment_reassembler #(
  parameter int BUF_BYTES = 4096,
  parameter int SEQ_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [1:0]  in_frag_flags,
  input  wire logic [31:0] in_seq_num,
  input  wire logic        in_frag_start,
  input  wire logic        in_frag_end,
  input  wire logic        in_byte_present,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_out_valid,
  output logic [7:0]       out_out_byte,
  output logic             out_out_packet_end,
  output logic [2:0]       out_status,
  output logic             out_dropped_partial,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data
);

  import fra_pkg::*;

  localparam int AW      = $clog2(BUF_BYTES);
  localparam int Q_DEPTH = 4;
  localparam int Q_W     = RES_W + 2 + AW;

  logic [LEN_W-1:0] max_len_r;
  logic             accept;
  res_t             f_res;
  logic             f_we, f_re;
  logic [AW-1:0]    f_addr;
  logic [Q_W-1:0]   q_in, q_head;
  logic             q_full, q_not_empty, q_pop;
  res_t             h_res;
  logic             h_we, h_re;
  logic [AW-1:0]    h_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LEN_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  fra_front #(
    .BUF_BYTES (BUF_BYTES),
    .SEQ_BITS  (SEQ_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .func         (in_func),
    .data_byte    (in_data_byte),
    .frag_flags   (in_frag_flags),
    .seq_num      (in_seq_num),
    .frag_start   (in_frag_start),
    .frag_end     (in_frag_end),
    .byte_present (in_byte_present),
    .max_length   (max_len_r),
    .res          (f_res),
    .mem_we       (f_we),
    .mem_re       (f_re),
    .mem_addr     (f_addr)
  );

  assign q_in = {f_res, f_we, f_re, f_addr};

  fra_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

  assign {h_res, h_we, h_re, h_addr} = q_head;

  fra_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_not_empty),
    .q_res               (h_res),
    .q_we                (h_we),
    .q_re                (h_re),
    .q_addr              (h_addr),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_out_valid       (out_out_valid),
    .out_out_byte        (out_out_byte),
    .out_out_packet_end  (out_out_packet_end),
    .out_status          (out_status),
    .out_dropped_partial (out_dropped_partial)
  );

  // A delivered byte comes only from a passed fragment or a packet read.
  a_byte_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_valid) |->
      (out_status == ST_PASSED || out_status == ST_READ))
    else $error("delivered byte with unexpected status");

  a_overflow_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OVERFLOW) |-> (out_dropped_partial && !out_out_valid))
    else $error("overflow beat without dropped reassembly");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |->
      (!out_out_valid && !out_out_packet_end && !out_dropped_partial && out_out_byte == 8'd0))
    else $error("read of an absent packet carries data");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

/* rtl/fra_fifo.sv */
`default_nettype none

module fra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wptr_r + 1'b1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/fra_front.sv */
`default_nettype none

module fra_front #(
  parameter int BUF_BYTES = 4096,
  parameter int SEQ_BITS  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic                          func,
  input  wire logic [7:0]                    data_byte,
  input  wire logic [1:0]                    frag_flags,
  input  wire logic [31:0]                   seq_num,
  input  wire logic                          frag_start,
  input  wire logic                          frag_end,
  input  wire logic                          byte_present,
  input  wire logic [fra_pkg::LEN_W-1:0]     max_length,
  output fra_pkg::res_t                      res,
  output logic                               mem_we,
  output logic                               mem_re,
  output logic [$clog2(BUF_BYTES)-1:0]       mem_addr
);

  import fra_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = $clog2(BUF_BYTES + 1);

  logic [CW-1:0]       fill_r, fill_nxt;
  logic                asm_r, asm_nxt;
  logic                rdy_r, rdy_nxt;
  logic [CW-1:0]       ridx_r, ridx_nxt;
  logic [SEQ_BITS-1:0] exp_r, exp_nxt;
  mode_t               mode_r, mode_nxt;

  logic [SEQ_BITS-1:0] seq;
  logic                refused;
  logic                over;
  logic [CW-1:0]       ridx_inc;

  assign seq      = seq_num[SEQ_BITS-1:0];
  assign ridx_inc = CW'(ridx_r + 1'b1);

  always_comb begin
    fill_nxt   = fill_r;
    asm_nxt    = asm_r;
    rdy_nxt    = rdy_r;
    ridx_nxt   = ridx_r;
    exp_nxt    = exp_r;
    mode_nxt   = mode_r;
    res        = '0;
    res.status = ST_DISCARDED;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = ridx_r[AW-1:0];
    refused    = 1'b0;
    over       = 1'b0;
    if (accept && func) begin
      if (!rdy_r) begin
        res.status = ST_EMPTY;
      end else begin
        res.status = ST_READ;
        if (fill_r == '0 || ridx_r >= fill_r) begin
          res.pend = 1'b1;
          rdy_nxt  = 1'b0;
          ridx_nxt = '0;
        end else begin
          res.valid = 1'b1;
          mem_re    = 1'b1;
          ridx_nxt  = ridx_inc;
          if (ridx_inc >= fill_r) begin
            res.pend = 1'b1;
            rdy_nxt  = 1'b0;
            ridx_nxt = '0;
            fill_nxt = '0;
          end
        end
      end
    end else if (accept) begin
      if (frag_start) begin
        if (seq != exp_r && asm_nxt) begin
          asm_nxt     = 1'b0;
          fill_nxt    = '0;
          res.dropped = 1'b1;
        end
        case (frag_flags)
          FLAG_SINGLE: begin
            if (asm_nxt) begin
              asm_nxt     = 1'b0;
              fill_nxt    = '0;
              res.dropped = 1'b1;
            end
            mode_nxt = MODE_PASS;
          end
          FLAG_FIRST: begin
            if (asm_nxt) begin
              asm_nxt     = 1'b0;
              fill_nxt    = '0;
              res.dropped = 1'b1;
            end
            if (rdy_r) begin
              mode_nxt = MODE_DISCARD;
              refused  = 1'b1;
            end else begin
              asm_nxt  = 1'b1;
              fill_nxt = '0;
              mode_nxt = MODE_APPEND;
            end
          end
          FLAG_LAST: begin
            mode_nxt = asm_nxt ? MODE_FINISH : MODE_DISCARD;
          end
          default: begin
            mode_nxt = asm_nxt ? MODE_APPEND : MODE_DISCARD;
          end
        endcase
        if (frag_flags != FLAG_SINGLE) begin
          exp_nxt = SEQ_BITS'(seq + 1'b1);
        end
      end

      over = (32'(fill_nxt) >= 32'(max_length)) || (32'(fill_nxt) >= 32'(BUF_BYTES));

      if (mode_nxt == MODE_PASS) begin
        res.status = ST_PASSED;
        if (byte_present) begin
          res.valid = 1'b1;
          res.data  = data_byte;
        end
        res.pend = frag_end;
      end else if (mode_nxt == MODE_APPEND || mode_nxt == MODE_FINISH) begin
        res.status = ST_STORED;
        if (byte_present) begin
          if (over) begin
            asm_nxt     = 1'b0;
            fill_nxt    = '0;
            res.dropped = 1'b1;
            mode_nxt    = MODE_DISCARD;
            res.status  = ST_OVERFLOW;
          end else begin
            mem_we   = 1'b1;
            mem_addr = fill_nxt[AW-1:0];
            res.data = data_byte;
            fill_nxt = CW'(fill_nxt + 1'b1);
          end
        end
        if (frag_end && mode_nxt == MODE_FINISH && asm_nxt) begin
          asm_nxt    = 1'b0;
          rdy_nxt    = 1'b1;
          ridx_nxt   = '0;
          res.status = ST_COMPLETE;
        end
      end else begin
        res.status = refused ? ST_BUSY : ST_DISCARDED;
      end
      if (refused) begin
        res.status = ST_BUSY;
      end
      if (frag_end) begin
        mode_nxt = MODE_DISCARD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      asm_r  <= 1'b0;
      rdy_r  <= 1'b0;
      ridx_r <= '0;
      exp_r  <= '0;
      mode_r <= MODE_DISCARD;
    end else begin
      fill_r <= fill_nxt;
      asm_r  <= asm_nxt;
      rdy_r  <= rdy_nxt;
      ridx_r <= ridx_nxt;
      exp_r  <= exp_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/fra_back.sv */
`default_nettype none

module fra_back #(
  parameter int BUF_BYTES = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire fra_pkg::res_t                 q_res,
  input  wire logic                          q_we,
  input  wire logic                          q_re,
  input  wire logic [$clog2(BUF_BYTES)-1:0]  q_addr,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_out_valid,
  output logic [7:0]                         out_out_byte,
  output logic                               out_out_packet_end,
  output logic [2:0]                         out_status,
  output logic                               out_dropped_partial
);

  import fra_pkg::*;

  logic [7:0] store_r [BUF_BYTES];
  logic [7:0] rd_r;
  logic       valid_r, valid_nxt;
  res_t       res_r;
  logic       sel_mem_r;

  // A stored byte travels in the data field; the result itself shows zero there.
  assign q_pop = q_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r     <= q_res;
      sel_mem_r <= q_re;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_we) begin
      store_r[q_addr] <= q_res.data;
    end
    if (q_pop && q_re) begin
      rd_r <= store_r[q_addr];
    end
  end

  assign out_valid           = valid_r;
  assign out_out_valid       = res_r.valid;
  assign out_out_byte        = sel_mem_r ? rd_r : (res_r.valid ? res_r.data : 8'd0);
  assign out_out_packet_end  = res_r.pend;
  assign out_status          = res_r.status;
  assign out_dropped_partial = res_r.dropped;

endmodule

`default_nettype wire

/* sim/fragment_reassembler_check.sv */
module fragment_reassembler_check
  import fra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  input  logic [1:0]  in_frag_flags,
  input  logic [31:0] in_seq_num,
  input  logic        in_frag_start,
  input  logic        in_frag_end,
  input  logic        in_byte_present,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_out_valid,
  input  logic [7:0]  out_out_byte,
  input  logic        out_out_packet_end,
  input  logic [2:0]  out_status,
  input  logic        out_dropped_partial,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [12:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked,
  output int          completed,
  output int          overflowed
);

  localparam logic [12:0] BUF_LIMIT = 13'd4096;

  logic [7:0]  pkt_mem [0:4095];
  logic [12:0] fill_cnt;
  logic [12:0] rd_idx;
  logic [12:0] max_len;
  logic        asm_open;
  logic        pkt_ready;
  logic [31:0] exp_seq;
  mode_t       frag_mode;
  res_t        result_q [$];

  function automatic res_t predict_beat(input logic func, input logic [7:0] data,
                                        input logic [1:0] flags, input logic [31:0] seq,
                                        input logic fstart, input logic fend,
                                        input logic present);
    res_t        r;
    logic        refused;
    logic [12:0] lim;
    r = '0;
    r.status = ST_DISCARDED;
    refused = 1'b0;
    lim = (max_len < BUF_LIMIT) ? max_len : BUF_LIMIT;
    if (func) begin
      if (!pkt_ready) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_READ;
        if (fill_cnt == 0 || rd_idx >= fill_cnt) begin
          r.pend = 1'b1;
          pkt_ready = 1'b0;
          rd_idx = '0;
        end else begin
          r.data = pkt_mem[rd_idx[11:0]];
          r.valid = 1'b1;
          rd_idx = rd_idx + 13'd1;
          if (rd_idx >= fill_cnt) begin
            r.pend = 1'b1;
            pkt_ready = 1'b0;
            rd_idx = '0;
            fill_cnt = '0;
          end
        end
      end
    end else begin
      if (fstart) begin
        if (seq != exp_seq && asm_open) begin
          asm_open = 1'b0;
          fill_cnt = '0;
          r.dropped = 1'b1;
        end
        case (flags)
          FLAG_SINGLE: begin
            if (asm_open) begin
              asm_open = 1'b0;
              fill_cnt = '0;
              r.dropped = 1'b1;
            end
            frag_mode = MODE_PASS;
          end
          FLAG_FIRST: begin
            if (asm_open) begin
              asm_open = 1'b0;
              fill_cnt = '0;
              r.dropped = 1'b1;
            end
            if (pkt_ready) begin
              frag_mode = MODE_DISCARD;
              refused = 1'b1;
            end else begin
              asm_open = 1'b1;
              fill_cnt = '0;
              frag_mode = MODE_APPEND;
            end
          end
          FLAG_LAST: frag_mode = asm_open ? MODE_FINISH : MODE_DISCARD;
          default: frag_mode = asm_open ? MODE_APPEND : MODE_DISCARD;
        endcase
        if (flags != FLAG_SINGLE) exp_seq = seq + 32'd1;
      end
      if (frag_mode == MODE_PASS) begin
        r.status = ST_PASSED;
        if (present) begin
          r.valid = 1'b1;
          r.data = data;
        end
        r.pend = fend;
      end else if (frag_mode == MODE_APPEND || frag_mode == MODE_FINISH) begin
        r.status = ST_STORED;
        if (present) begin
          if (fill_cnt >= lim) begin
            asm_open = 1'b0;
            fill_cnt = '0;
            r.dropped = 1'b1;
            frag_mode = MODE_DISCARD;
            r.status = ST_OVERFLOW;
          end else begin
            pkt_mem[fill_cnt[11:0]] = data;
            fill_cnt = fill_cnt + 13'd1;
          end
        end
        if (fend && frag_mode == MODE_FINISH && asm_open) begin
          asm_open = 1'b0;
          pkt_ready = 1'b1;
          rd_idx = '0;
          r.status = ST_COMPLETE;
        end
      end else begin
        r.status = refused ? ST_BUSY : ST_DISCARDED;
      end
      if (refused) r.status = ST_BUSY;
      if (fend) frag_mode = MODE_DISCARD;
    end
    return r;
  endfunction

  task automatic report_field(input string name, input int exp_v, input int act_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    res_t exp_r;
    if (!rst_n) begin
      fill_cnt = '0;
      rd_idx = '0;
      max_len = BUF_LIMIT;
      asm_open = 1'b0;
      pkt_ready = 1'b0;
      exp_seq = '0;
      frag_mode = MODE_DISCARD;
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (result_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d", $time, out_status);
          mismatches++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_out_valid !== exp_r.valid)
            report_field("out_valid", exp_r.valid, out_out_valid);
          if (out_out_byte !== exp_r.data)
            report_field("out_byte", exp_r.data, out_out_byte);
          if (out_out_packet_end !== exp_r.pend)
            report_field("out_packet_end", exp_r.pend, out_out_packet_end);
          if (out_status !== exp_r.status)
            report_field("status", exp_r.status, out_status);
          if (out_dropped_partial !== exp_r.dropped)
            report_field("dropped_partial", exp_r.dropped, out_dropped_partial);
          if (exp_r.status == ST_COMPLETE) completed++;
          if (exp_r.status == ST_OVERFLOW) overflowed++;
        end
      end
      if (cfg_valid && cfg_ready) max_len = cfg_data;
      if (in_valid && !in_stall)
        result_q.push_back(predict_beat(in_func, in_data_byte, in_frag_flags, in_seq_num,
                                        in_frag_start, in_frag_end, in_byte_present));
    end
    pending = result_q.size();
  end

endmodule

/* sim/fragment_reassembler_test.sv */
module fragment_reassembler_test
  import fra_pkg::*;
;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BEATS = 240;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [7:0]  in_data_byte;
  logic [1:0]  in_frag_flags;
  logic [31:0] in_seq_num;
  logic        in_frag_start;
  logic        in_frag_end;
  logic        in_byte_present;
  logic        out_valid;
  logic        out_stall;
  logic        out_out_valid;
  logic [7:0]  out_out_byte;
  logic        out_out_packet_end;
  logic [2:0]  out_status;
  logic        out_dropped_partial;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_data;

  int          mismatches;
  int          pending;
  int          checked;
  int          completed;
  int          overflowed;
  int          beats_sent;
  int          limit_writes;
  logic [31:0] next_seq;
  bit          calm_in;
  bit          calm_out;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fragment_reassembler u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_data_byte        (in_data_byte),
    .in_frag_flags       (in_frag_flags),
    .in_seq_num          (in_seq_num),
    .in_frag_start       (in_frag_start),
    .in_frag_end         (in_frag_end),
    .in_byte_present     (in_byte_present),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_out_valid       (out_out_valid),
    .out_out_byte        (out_out_byte),
    .out_out_packet_end  (out_out_packet_end),
    .out_status          (out_status),
    .out_dropped_partial (out_dropped_partial),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  fragment_reassembler_check u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_data_byte        (in_data_byte),
    .in_frag_flags       (in_frag_flags),
    .in_seq_num          (in_seq_num),
    .in_frag_start       (in_frag_start),
    .in_frag_end         (in_frag_end),
    .in_byte_present     (in_byte_present),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_out_valid       (out_out_valid),
    .out_out_byte        (out_out_byte),
    .out_out_packet_end  (out_out_packet_end),
    .out_status          (out_status),
    .out_dropped_partial (out_dropped_partial),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .mismatches          (mismatches),
    .pending             (pending),
    .checked             (checked),
    .completed           (completed),
    .overflowed          (overflowed)
  );

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : pace_switch
    calm_in = 1'b0;
    calm_out = 1'b0;
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      calm_in = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : sink_pace
    int n;
    out_stall = 1'b0;
    forever begin
      n = pick_gap(calm_out);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      n = $urandom_range(1, 12);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(input logic func, input logic [7:0] data,
                           input logic [1:0] flags, input logic [31:0] seq,
                           input logic fstart, input logic fend, input logic present);
    int gap;
    gap = pick_gap(calm_in);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= func;
    in_data_byte <= data;
    in_frag_flags <= flags;
    in_seq_num <= seq;
    in_frag_start <= fstart;
    in_frag_end <= fend;
    in_byte_present <= present;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_fragment(input logic [1:0] flags, input logic [31:0] seq, input int len);
    int i;
    if (len == 0) begin
      send_beat(1'b0, $urandom_range(0, 255), flags, seq, 1'b1, 1'b1, 1'b0);
    end else begin
      for (i = 0; i < len; i++)
        send_beat(1'b0, $urandom_range(0, 255), flags, seq, i == 0, i == len - 1, 1'b1);
    end
  endtask

  task automatic send_reads(input int n);
    repeat (n)
      send_beat(1'b1, $urandom_range(0, 255), $urandom_range(0, 3), $urandom,
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  task automatic set_max_len(input logic [12:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  task automatic send_packet();
    int          nfrag;
    int          total;
    int          len;
    int          k;
    logic [1:0]  flags;
    logic [31:0] s;
    s = ($urandom_range(0, 3) == 0) ? $urandom : next_seq;
    nfrag = $urandom_range(2, 5);
    total = 0;
    for (k = 0; k < nfrag; k++) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      flags = (k == 0) ? FLAG_FIRST : ((k == nfrag - 1) ? FLAG_LAST : FLAG_MIDDLE);
      if ($urandom_range(0, 19) == 0) s = s + 32'd2;
      if ($urandom_range(0, 24) != 0) begin
        send_fragment(flags, s, len);
        total += len;
      end
      if ($urandom_range(0, 29) == 0)
        send_beat(1'b0, $urandom_range(0, 255), $urandom_range(0, 3), s, 1'b0,
                  $urandom_range(0, 1), $urandom_range(0, 1));
      s = s + 32'd1;
    end
    next_seq = s;
    if ($urandom_range(0, 6) != 0) send_reads(total + $urandom_range(0, 1));
    else send_reads($urandom_range(0, total));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 3))
      send_beat($urandom_range(0, 4) == 0, $urandom_range(0, 255), $urandom_range(0, 3),
                ($urandom_range(0, 1) == 0) ? next_seq : $urandom,
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  initial begin : stimulus
    logic [12:0] limits [0:6];
    int          p;
    int          r;
    int          start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_data_byte = '0;
    in_frag_flags = '0;
    in_seq_num = '0;
    in_frag_start = 1'b0;
    in_frag_end = 1'b0;
    in_byte_present = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    beats_sent = 0;
    limit_writes = 0;
    limits[0] = 13'd5;
    limits[1] = 13'd12;
    limits[2] = 13'd4096;
    limits[3] = 13'd1;
    limits[4] = 13'($urandom_range(1, 4096));
    limits[5] = 13'd20;
    limits[6] = 13'd3;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_beat(1'b1, 8'hFF, FLAG_SINGLE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_beat(1'b0, 8'h00, FLAG_SINGLE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
    send_beat(1'b0, 8'hFF, FLAG_SINGLE, 32'h0, 1'b0, 1'b1, 1'b1);
    send_beat(1'b0, 8'hA5, FLAG_SINGLE, 32'h1234, 1'b1, 1'b1, 1'b0);
    send_beat(1'b0, 8'h3C, FLAG_MIDDLE, 32'h7, 1'b1, 1'b1, 1'b1);
    send_fragment(FLAG_FIRST, 32'hFFFF_FFFF, 2);
    send_fragment(FLAG_LAST, 32'h0, 1);
    send_fragment(FLAG_FIRST, 32'h1, 1);
    send_reads(4);
    send_beat(1'b0, 8'h81, FLAG_FIRST, 32'h2, 1'b0, 1'b0, 1'b1);
    send_fragment(FLAG_FIRST, 32'h5, 1);
    send_fragment(FLAG_MIDDLE, 32'h9, 1);
    send_fragment(FLAG_FIRST, 32'hA, 0);
    send_fragment(FLAG_LAST, 32'hB, 0);
    send_reads(1);
    send_fragment(FLAG_FIRST, 32'h14, 2);
    send_fragment(FLAG_SINGLE, 32'h15, 1);
    send_fragment(FLAG_LAST, 32'h16, 1);
    set_max_len(13'd1);
    send_fragment(FLAG_FIRST, 32'h30, 2);
    next_seq = 32'h31;

    for (p = 0; p < 7; p++) begin
      set_max_len(limits[p]);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        if (r < 55) send_packet();
        else if (r < 70) send_reads($urandom_range(1, 4));
        else if (r < 82) send_fragment(FLAG_SINGLE,
                                       ($urandom_range(0, 1) == 0) ? next_seq : $urandom,
                                       $urandom_range(0, 5));
        else send_noise();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d beats across %0d length limit settings; checked %0d results.",
             beats_sent, limit_writes, checked);
    $display("Reassembled %0d packets and saw %0d overflows; %0d mismatches.",
             completed, overflowed, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no beat moved for %0d cycles, %0d results outstanding.",
             QUIET_LIMIT, pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
